// ===== design/b256m_pkg.sv =====
// Package for the binary256 multiplier: format constants and the per-stage
// side-band record. No dependencies.
`default_nettype none
package b256m_pkg;
    localparam int EXP_W   = 19;
    localparam int FRAC_W  = 236;
    localparam int DIGIT_W = 32;
    localparam int NDIG    = 8;
    localparam logic [EXP_W-1:0] EXP_ONES   = 19'h7FFFF;
    localparam logic [20:0]      EXP_OFFSET = 21'h03FFFF;

    typedef struct packed {
        logic         valid;
        logic         special;
        logic         sign;
        logic [19:0]  esum;
        logic [255:0] spec_word;
    } meta_t;
endpackage
`default_nettype wire

// ===== design/binary256_float_multiplier_top.sv =====
// Pipelined binary256 floating-point multiplier, truncating, underflowing results flushed to zero.
// Depends on b256m_pkg.
//
// Usage: operands enter on the s_ channel (valid/ready), one pair per
// transfer, each operand as four 64-bit words with word3 most significant.
// The product leaves on the m_ channel as four 64-bit words.
// Throughput is one product per cycle while the receiver keeps up: stage 1
// forms 64 32x32 partial products, stages 2 to 7 sum them in a registered
// adder tree, stage 8 normalizes and packs.
// The whole pipeline advances together; when the receiver stalls with a
// result waiting, every stage holds and s_ready falls, so nothing is lost or
// repeated. Bubbles advance freely while m_valid is low.
// Reset clears all valid bits; the data registers are not reset.
`default_nettype none
module binary256_float_multiplier_top
    import b256m_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [63:0] s_a_word3,
    input  wire logic [63:0] s_a_word2,
    input  wire logic [63:0] s_a_word1,
    input  wire logic [63:0] s_a_word0,
    input  wire logic [63:0] s_b_word3,
    input  wire logic [63:0] s_b_word2,
    input  wire logic [63:0] s_b_word1,
    input  wire logic [63:0] s_b_word0,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_prod_word3,
    output logic [63:0]      m_prod_word2,
    output logic [63:0]      m_prod_word1,
    output logic [63:0]      m_prod_word0
);
    logic advance;
    logic [255:0] a_w, b_w;
    logic [EXP_W-1:0] ea, eb;
    logic [255:0] da_w, db_w;
    meta_t m0, m1_reg, m2_reg, m3_reg, m4_reg, m5_reg, m6_reg, m7_reg;
    logic [63:0]  pp_next [NDIG][NDIG];
    logic [63:0]  pp_reg  [NDIG][NDIG];
    logic [95:0]  r2_next [NDIG][4];
    logic [95:0]  r2_reg  [NDIG][4];
    logic [159:0] r3_next [NDIG][2];
    logic [159:0] r3_reg  [NDIG][2];
    logic [287:0] r4_next [NDIG];
    logic [287:0] r4_reg  [NDIG];
    logic [319:0] r5_next [4];
    logic [319:0] r5_reg  [4];
    logic [383:0] r6_next [2];
    logic [383:0] r6_reg  [2];
    logic [511:0] p_next, p_reg;
    logic         carry;
    logic [20:0]  e;
    logic [FRAC_W-1:0] frac;
    logic [255:0] out_next, out_reg;
    logic         out_valid_reg;

    assign advance = m_ready || !out_valid_reg;
    assign s_ready = advance;

    assign a_w = {s_a_word3, s_a_word2, s_a_word1, s_a_word0};
    assign b_w = {s_b_word3, s_b_word2, s_b_word1, s_b_word0};
    assign ea  = a_w[254:236];
    assign eb  = b_w[254:236];
    assign da_w = {19'b0, 1'b1, a_w[235:0]};
    assign db_w = {19'b0, 1'b1, b_w[235:0]};

    always_comb begin
        m0.valid     = s_valid;
        m0.sign      = a_w[255] ^ b_w[255];
        m0.esum      = 20'(ea) + 20'(eb);
        m0.special   = 1'b1;
        if (ea == EXP_ONES || ea == '0) begin
            m0.spec_word = {a_w[255] ^ b_w[255], a_w[254:0]};
        end else if (eb == EXP_ONES || eb == '0) begin
            m0.spec_word = {b_w[255] ^ a_w[255], b_w[254:0]};
        end else begin
            m0.special   = 1'b0;
            m0.spec_word = a_w;
        end
        for (int i = 0; i < NDIG; i++) begin
            for (int j = 0; j < NDIG; j++) begin
                pp_next[i][j] = 64'(da_w[i*DIGIT_W +: DIGIT_W]) *
                                64'(db_w[j*DIGIT_W +: DIGIT_W]);
            end
        end
        for (int i = 0; i < NDIG; i++) begin
            for (int k = 0; k < 4; k++) begin
                r2_next[i][k] = 96'(pp_reg[i][2*k]) + {pp_reg[i][2*k+1], 32'b0};
            end
            for (int k = 0; k < 2; k++) begin
                r3_next[i][k] = 160'(r2_reg[i][2*k]) + {r2_reg[i][2*k+1], 64'b0};
            end
            r4_next[i] = 288'(r3_reg[i][0]) + {r3_reg[i][1][159:0], 128'b0};
        end
        for (int k = 0; k < 4; k++) begin
            r5_next[k] = 320'(r4_reg[2*k]) + {r4_reg[2*k+1], 32'b0};
        end
        for (int k = 0; k < 2; k++) begin
            r6_next[k] = 384'(r5_reg[2*k]) + {r5_reg[2*k+1], 64'b0};
        end
        p_next = 512'(r6_reg[0]) + {r6_reg[1], 128'b0};
    end

    always_comb begin
        carry = p_reg[473];
        frac  = carry ? p_reg[472:237] : p_reg[471:236];
        e     = 21'(m7_reg.esum) + 21'(carry) - EXP_OFFSET;
        if (m7_reg.special) begin
            out_next = m7_reg.spec_word;
        end else if ($signed(e) < 21'sd1) begin
            out_next = {m7_reg.sign, 255'b0};
        end else if ($signed(e) >= $signed({2'b0, EXP_ONES})) begin
            out_next = {m7_reg.sign, EXP_ONES, 236'b0};
        end else begin
            out_next = {m7_reg.sign, e[EXP_W-1:0], frac};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_reg.valid  <= 1'b0;
            m2_reg.valid  <= 1'b0;
            m3_reg.valid  <= 1'b0;
            m4_reg.valid  <= 1'b0;
            m5_reg.valid  <= 1'b0;
            m6_reg.valid  <= 1'b0;
            m7_reg.valid  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            m1_reg  <= m0;
            m2_reg  <= m1_reg;
            m3_reg  <= m2_reg;
            m4_reg  <= m3_reg;
            m5_reg  <= m4_reg;
            m6_reg  <= m5_reg;
            m7_reg  <= m6_reg;
            pp_reg  <= pp_next;
            r2_reg  <= r2_next;
            r3_reg  <= r3_next;
            r4_reg  <= r4_next;
            r5_reg  <= r5_next;
            r6_reg  <= r6_next;
            p_reg   <= p_next;
            out_reg <= out_next;
            out_valid_reg <= m7_reg.valid;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_prod_word3 = out_reg[255:192];
    assign m_prod_word2 = out_reg[191:128];
    assign m_prod_word1 = out_reg[127:64];
    assign m_prod_word0 = out_reg[63:0];
endmodule
`default_nettype wire

// ===== sim/binary256_float_multiplier_top_tb.sv =====
// Self-checking testbench for the binary256 float multiplier top level.
// Depends on b256m_pkg and binary256_float_multiplier_top; predicts each product itself.
`default_nettype none
module binary256_float_multiplier_top_tb;
    import b256m_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [255:0] a;
        logic [255:0] b;
    } operand_pair_t;

    class product_scoreboard;
        logic [255:0] pending_products[$];
        int errors = 0;

        function logic [255:0] multiply(logic [255:0] a, logic [255:0] b);
            logic [EXP_W-1:0] ea;
            logic [EXP_W-1:0] eb;
            logic sign;
            logic [236:0] siga;
            logic [236:0] sigb;
            logic [473:0] prod;
            logic carry;
            int signed e;
            logic [235:0] frac;
            ea = a[254:236];
            eb = b[254:236];
            sign = a[255] ^ b[255];
            if (ea == EXP_ONES || ea == '0) return {a[255] ^ b[255], a[254:0]};
            if (eb == EXP_ONES || eb == '0) return {b[255] ^ a[255], b[254:0]};
            siga = {1'b1, a[235:0]};
            sigb = {1'b1, b[235:0]};
            prod = siga * sigb;
            carry = prod[473];
            e = int'(ea) + int'(eb) - int'(EXP_OFFSET) + (carry ? 1 : 0);
            if (e < 1) return {sign, 255'b0};
            if (e >= int'(EXP_ONES)) return {sign, EXP_ONES, 236'b0};
            frac = carry ? prod[472:237] : prod[471:236];
            return {sign, e[EXP_W-1:0], frac};
        endfunction

        function void note_operands(operand_pair_t op);
            pending_products.push_back(multiply(op.a, op.b));
        endfunction

        function void check_product(logic [255:0] got);
            logic [255:0] want;
            if (pending_products.size() == 0) begin
                $error("unexpected product %h", got);
                errors++;
                return;
            end
            want = pending_products.pop_front();
            for (int w = 3; w >= 0; w--) begin
                if (got[w*64 +: 64] !== want[w*64 +: 64]) begin
                    $error("prod_word%0d expected %h actual %h", w, want[w*64 +: 64],
                           got[w*64 +: 64]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [255:0] s_a = '0;
    logic [255:0] s_b = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [63:0] m_prod_word3, m_prod_word2, m_prod_word1, m_prod_word0;

    product_scoreboard board = new();
    int idle_pct = 27;
    bit hold_off = 1'b0;
    int quiet_cycles = 0;

    always #10 aclk = ~aclk;

    binary256_float_multiplier_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_a_word3(s_a[255:192]), .s_a_word2(s_a[191:128]),
        .s_a_word1(s_a[127:64]), .s_a_word0(s_a[63:0]),
        .s_b_word3(s_b[255:192]), .s_b_word2(s_b[191:128]),
        .s_b_word1(s_b[127:64]), .s_b_word0(s_b[63:0]),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_prod_word3(m_prod_word3), .m_prod_word2(m_prod_word2),
        .m_prod_word1(m_prod_word1), .m_prod_word0(m_prod_word0)
    );

    function automatic logic [255:0] random_bits();
        return {$urandom(), $urandom(), $urandom(), $urandom(),
                $urandom(), $urandom(), $urandom(), $urandom()};
    endfunction

    function automatic logic [255:0] make_float(bit sign, logic [EXP_W-1:0] exp_field,
                                                logic [255:0] frac_bits);
        return {sign, exp_field, frac_bits[235:0]};
    endfunction

    function automatic logic [EXP_W-1:0] random_exponent();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) return '0;
        if (pick < 10) return EXP_ONES;
        if (pick < 20) return EXP_W'($urandom_range(1, 'h3FFFF));
        if (pick < 30) return EXP_W'($urandom_range('h3FFFF, 'h7FFFE));
        if (pick < 40) return EXP_W'($urandom_range(1, 'h20));
        if (pick < 50) return EXP_W'($urandom_range('h7FFE0, 'h7FFFE));
        return EXP_W'($urandom_range('h3FFFF - 'h1000, 'h3FFFF + 'h1000));
    endfunction

    function automatic logic [255:0] random_fraction();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return random_bits();
        endcase
    endfunction

    // Each transfer is noted in the scoreboard at the edge that accepts it.
    task automatic send_operands(logic [255:0] a, logic [255:0] b);
        while (!hold_off && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_a <= a;
        s_b <= b;
        do @(posedge aclk); while (!s_ready);
        board.note_operands('{a, b});
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (board.pending_products.size() != 0) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_product({m_prod_word3, m_prod_word2, m_prod_word1, m_prod_word0});
        end
    end

    always @(posedge aclk) begin
        if (hold_off) m_ready <= 1'b0;
        else m_ready <= !(idle_pct > 0 && $urandom_range(0, 99) < idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 2000) begin
            $display("binary256_float_multiplier_top: mismatch");
            $finish;
        end
    end

    initial begin
        logic [255:0] one_val;
        logic [255:0] max_norm;
        logic [255:0] min_norm;
        one_val = make_float(1'b0, 19'h3FFFF, '0);
        max_norm = make_float(1'b0, 19'h7FFFE, '1);
        min_norm = make_float(1'b0, 19'h00001, '0);
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_operands(one_val, one_val);
        send_operands(max_norm, max_norm);
        send_operands(min_norm, min_norm);
        send_operands(make_float(1'b1, 19'h3FFFF, '1), make_float(1'b0, 19'h3FFFF, '1));
        send_operands(make_float(1'b1, '0, '0), max_norm);
        send_operands(make_float(1'b0, '0, random_bits()), make_float(1'b1, 19'h40000, '0));
        send_operands(make_float(1'b1, EXP_ONES, '0), one_val);
        send_operands(make_float(1'b0, EXP_ONES, random_bits()), make_float(1'b1, '0, '0));
        send_operands(one_val, make_float(1'b1, EXP_ONES, '0));
        send_operands(make_float(1'b1, 19'h12345, '1), make_float(1'b1, '0, random_bits()));
        send_operands(max_norm, one_val);
        send_operands(min_norm, make_float(1'b1, 19'h3FFFE, '1));
        send_operands(make_float(1'b0, 19'h40000, '0), make_float(1'b0, 19'h3FFFF, '0));
        send_operands(make_float(1'b0, 19'h20000, '0), make_float(1'b0, 19'h1FFFF, '1));
        send_operands(make_float(1'b1, 19'h60000, '1), make_float(1'b0, 19'h60000, '0));
        send_operands('1, '1);
        send_operands('0, '0);

        for (int i = 0; i < 500; i++) begin
            if (i == 100) begin
                wait_for_drain();
                repeat ($urandom_range(5, 30)) @(posedge aclk);
            end
            if (i == 150) idle_pct = 0;
            if (i == 250) idle_pct = 27;
            if (i == 300) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (60) @(posedge aclk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            send_operands(make_float(1'($urandom_range(0, 1)), random_exponent(),
                                     random_fraction()),
                          make_float(1'($urandom_range(0, 1)), random_exponent(),
                                     random_fraction()));
        end

        wait_for_drain();
        repeat (20) @(posedge aclk);
        if (board.errors == 0) begin
            $display("binary256_float_multiplier_top: match");
        end else begin
            $display("binary256_float_multiplier_top: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire
